### rtl/tdq_pkg.sv
`timescale 1ns / 1ps

package tdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int MAX_BURST_DEF   = 32;

  localparam int HANDLE_W      = 16;
  localparam int TIME_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 11;
  localparam int MAX_RELEASE_W = 6;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RELEASE   = 1'd1;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_CHECK   = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef enum logic [2:0] {
    RES_ENQ,
    RES_FULL,
    RES_REL,
    RES_REL_LAST,
    RES_NONE
  } result_kind_t;

  typedef struct packed {
    logic         latch;
    logic         write;
    logic         pop;
    logic         push;
    result_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic op_check;
    logic full;
    logic empty;
    logic due;
    logic burst_ok;
    logic pend_valid;
    logic slot_free;
  } dp_status_t;

endpackage

### rtl/tdq_if.sv
`timescale 1ns / 1ps

interface tdq_item_if;
  import tdq_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [HANDLE_W-1:0] packet_handle;
  logic [TIME_W-1:0]   timestamp;

  modport source (output valid, operation, packet_handle, timestamp, input ready);
  modport sink (input valid, operation, packet_handle, timestamp, output ready);
endinterface

interface tdq_result_if;
  import tdq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [HANDLE_W-1:0]    released_handle;
  logic                   last_result;
  logic [COUNT_OUT_W-1:0] queue_count;

  modport source (output valid, status, released_handle, last_result, queue_count,
                  input ready);
  modport sink (input valid, status, released_handle, last_result, queue_count,
                output ready);
endinterface

### rtl/tdq_ctrl.sv
`timescale 1ns / 1ps

module tdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tdq_pkg::dp_status_t st,
  output tdq_pkg::dp_cmd_t    cmd
);
  import tdq_pkg::*;

  state_t state;
  state_t state_next;
  logic   go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign go = !st.empty && st.burst_ok && st.due;

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '{latch: 1'b0, write: 1'b0, pop: 1'b0, push: 1'b0, kind: RES_NONE};
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!st.op_check) begin
          if (st.slot_free) begin
            cmd.push   = 1'b1;
            cmd.kind   = st.full ? RES_FULL : RES_ENQ;
            cmd.write  = !st.full;
            state_next = S_IDLE;
          end
        end else if (go) begin
          // The previous release goes out now that another one follows it.
          if (!st.pend_valid || st.slot_free) begin
            cmd.pop  = 1'b1;
            cmd.push = st.pend_valid;
            cmd.kind = RES_REL;
          end
        end else if (st.slot_free) begin
          cmd.push   = 1'b1;
          cmd.kind   = st.pend_valid ? RES_REL_LAST : RES_NONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/tdq_dp.sv
`timescale 1ns / 1ps

module tdq_dp #(
  parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BURST   = tdq_pkg::MAX_BURST_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_operation,
  input  logic [tdq_pkg::HANDLE_W-1:0]    item_handle,
  input  logic [tdq_pkg::TIME_W-1:0]      item_time,
  input  tdq_pkg::dp_cmd_t                cmd,
  output tdq_pkg::dp_status_t             st,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [tdq_pkg::STATUS_W-1:0]    result_status,
  output logic [tdq_pkg::HANDLE_W-1:0]    result_handle,
  output logic                            result_last,
  output logic [tdq_pkg::COUNT_OUT_W-1:0] result_count
);
  import tdq_pkg::*;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int BURST_W = $clog2(MAX_BURST + 1);
  localparam int LIMIT_W = MAX_RELEASE_W + 1;
  localparam int ENTRY_W = TIME_W + HANDLE_W;

  logic [TIME_W-1:0]        delay_timeout;
  logic [MAX_RELEASE_W-1:0] max_release;

  logic                op_check;
  logic [HANDLE_W-1:0] cur_handle;
  logic [TIME_W-1:0]   cur_time;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail;
  logic [CNT_W-1:0]   count;

  logic [BURST_W-1:0]  burst;
  logic                pend_valid;
  logic [HANDLE_W-1:0] pend_handle;

  logic [LIMIT_W-1:0] limit;
  logic [TIME_W-1:0]  age;
  logic               slot_free;
  logic               full;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_timeout <= '0;
      max_release   <= MAX_RELEASE_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_TIMEOUT: delay_timeout <= cfg_data[TIME_W-1:0];
        REG_MAX_RELEASE:   max_release   <= cfg_data[MAX_RELEASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_check   <= item_operation;
      cur_handle <= item_handle;
      cur_time   <= item_time;
    end
  end

  // The read address runs one pop ahead, so rd_data always holds the current head.
  assign head_next = cmd.pop ? idx_inc(head) : head;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[tail] <= {cur_time, cur_handle};
    end
    rd_data <= mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (cmd.write) begin
        tail <= idx_inc(tail);
      end
      if (cmd.write) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst      <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.latch) begin
      burst      <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.pop) begin
      burst      <= burst + 1'b1;
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pend_handle <= rd_data[HANDLE_W-1:0];
    end
  end

  // A limit of zero means one; anything above the burst size is clipped.
  always_comb begin
    if (max_release == '0) begin
      limit = LIMIT_W'(1);
    end else if ({1'b0, max_release} > LIMIT_W'(MAX_BURST)) begin
      limit = LIMIT_W'(MAX_BURST);
    end else begin
      limit = {1'b0, max_release};
    end
  end

  assign age       = cur_time - rd_data[ENTRY_W-1:HANDLE_W];
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign slot_free = !result_valid || result_ready;

  assign st.op_check   = (op_check == OP_CHECK);
  assign st.full       = full;
  assign st.empty      = (count == '0);
  assign st.due        = (age >= delay_timeout);
  assign st.burst_ok   = (LIMIT_W'(burst) < limit);
  assign st.pend_valid = pend_valid;
  assign st.slot_free  = slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      case (cmd.kind)
        RES_ENQ: begin
          result_status <= ST_ENQUEUED;
          result_handle <= '0;
          result_last   <= 1'b1;
          result_count  <= COUNT_OUT_W'(count + 1'b1);
        end
        RES_FULL: begin
          result_status <= ST_FULL;
          result_handle <= '0;
          result_last   <= 1'b1;
          result_count  <= COUNT_OUT_W'(count);
        end
        RES_REL: begin
          result_status <= ST_RELEASED;
          result_handle <= pend_handle;
          result_last   <= 1'b0;
          result_count  <= COUNT_OUT_W'(count);
        end
        RES_REL_LAST: begin
          result_status <= ST_RELEASED;
          result_handle <= pend_handle;
          result_last   <= 1'b1;
          result_count  <= COUNT_OUT_W'(count);
        end
        default: begin
          result_status <= ST_NONE_DUE;
          result_handle <= '0;
          result_last   <= 1'b1;
          result_count  <= COUNT_OUT_W'(count);
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count != '0) && (LIMIT_W'(burst) < limit))
    else $error("pop from empty queue or past burst limit");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !full && !cmd.pop)
    else $error("write into full queue");

  a_push_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> slot_free)
    else $error("result overwritten before transaction");

  a_pop_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && !cmd.latch |=> pend_valid)
    else $error("released handle not held after pop");

endmodule

### rtl/timestamp_delay_queue.sv
`timescale 1ns / 1ps

// Channel   Modport  Transaction
// item      sink     operation, packet_handle, timestamp
// result    source   status, released_handle, last_result, queue_count
// cfg_*     input    write of delay_timeout (index 0) or max_release (index 1)
//
// An enqueue passes through the accept state and then the execute state.
// In a check, the head memory read is prefetched at the next head address, so
// one handle leaves per cycle while each result is taken without a stall.
// Reset clears indices, count and control; the stores need no clearing pass.
// A stalled result register holds the release loop until it is taken.
module timestamp_delay_queue #(
  parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BURST   = tdq_pkg::MAX_BURST_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdq_pkg::CFG_DATA_W-1:0] cfg_data,
  tdq_item_if.sink                       item,
  tdq_result_if.source                   result
);
  import tdq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  tdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .st         (st),
    .cmd        (cmd)
  );

  tdq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BURST   (MAX_BURST)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_operation (item.operation),
    .item_handle    (item.packet_handle),
    .item_time      (item.timestamp),
    .cmd            (cmd),
    .st             (st),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_status  (result.status),
    .result_handle  (result.released_handle),
    .result_last    (result.last_result),
    .result_count   (result.queue_count)
  );

endmodule

### tb/tdq_checker.sv
`timescale 1ns / 1ps

module tdq_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdq_pkg::CFG_DATA_W-1:0] cfg_data,
  tdq_item_if                            item,
  tdq_result_if                          result,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_results
);
  import tdq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int BURST = MAX_BURST_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [HANDLE_W-1:0]    handle;
    logic                   last;
    logic [COUNT_OUT_W-1:0] count;
  } queue_result_t;

  logic [HANDLE_W-1:0]      handle_mem [DEPTH];
  logic [TIME_W-1:0]        arrival_mem [DEPTH];
  int unsigned              head_ptr;
  int unsigned              tail_ptr;
  int unsigned              held;
  logic [TIME_W-1:0]        timeout_ticks;
  logic [MAX_RELEASE_W-1:0] burst_reg;
  queue_result_t            expected_results [$];

  function automatic queue_result_t make_result(input logic [STATUS_W-1:0] status,
                                                input logic [HANDLE_W-1:0] handle,
                                                input logic last);
    queue_result_t r;
    r.status = status;
    r.handle = handle;
    r.last   = last;
    r.count  = held[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic predict_transaction(input logic op, input logic [HANDLE_W-1:0] handle,
                                     input logic [TIME_W-1:0] stamp);
    int unsigned       limit;
    int unsigned       released;
    logic [TIME_W-1:0] age;
    if (op == OP_ENQUEUE) begin
      if (held >= DEPTH) begin
        expected_results.push_back(make_result(ST_FULL, '0, 1'b1));
      end else begin
        handle_mem[tail_ptr]  = handle;
        arrival_mem[tail_ptr] = stamp;
        tail_ptr = (tail_ptr + 1) % DEPTH;
        held++;
        expected_results.push_back(make_result(ST_ENQUEUED, '0, 1'b1));
      end
    end else begin
      limit = int'(burst_reg);
      if (limit == 0) limit = 1;
      if (limit > BURST) limit = BURST;
      released = 0;
      while (released < limit && held > 0) begin
        age = stamp - arrival_mem[head_ptr];
        if (age < timeout_ticks) break;
        held--;
        expected_results.push_back(make_result(ST_RELEASED, handle_mem[head_ptr], 1'b0));
        head_ptr = (head_ptr + 1) % DEPTH;
        released++;
      end
      if (released == 0) begin
        expected_results.push_back(make_result(ST_NONE_DUE, '0, 1'b1));
      end else begin
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst) begin
      head_ptr      = 0;
      tail_ptr      = 0;
      held          = 0;
      timeout_ticks = '0;
      burst_reg     = MAX_RELEASE_W'(BURST);
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DELAY_TIMEOUT: timeout_ticks = cfg_data[TIME_W-1:0];
          REG_MAX_RELEASE:   burst_reg = cfg_data[MAX_RELEASE_W-1:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        predict_transaction(item.operation, item.packet_handle, item.timestamp);
      end
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result transaction: status %0d handle %h last %0b count %0d",
                     $time, result.status, result.released_handle, result.last_result,
                     result.queue_count);
          end
        end else begin
          exp_r = expected_results.pop_front();
          if (result.status !== exp_r.status || result.released_handle !== exp_r.handle ||
              result.last_result !== exp_r.last || result.queue_count !== exp_r.count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch: expected status %0d handle %h last %0b count %0d",
                       $time, exp_r.status, exp_r.handle, exp_r.last, exp_r.count);
              $display("%0t:                  actual   status %0d handle %h last %0b count %0d",
                       $time, result.status, result.released_handle, result.last_result,
                       result.queue_count);
            end
          end
        end
      end
    end
  end

  // Published away from the active edge so the stimulus reads a settled value.
  always @(negedge clk) begin
    pending_results <= expected_results.size();
  end

endmodule

### tb/tb_timestamp_delay_queue.sv
`timescale 1ns / 1ps

module tb_timestamp_delay_queue;
  import tdq_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatch_count;
  int unsigned           pending_results;
  logic                  send_gaps    = 1'b1;
  logic                  take_gaps    = 1'b1;
  logic                  hold_request = 1'b0;
  logic [TIME_W-1:0]     now;

  tdq_item_if   item_ch ();
  tdq_result_if result_ch ();

  timestamp_delay_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  tdq_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item            (item_ch),
    .result          (result_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold on each request.
  initial begin : result_sink
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (take_gaps && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic op, input logic [HANDLE_W-1:0] handle,
                           input logic [TIME_W-1:0] stamp);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.operation     <= op;
    item_ch.packet_handle <= handle;
    item_ch.timestamp     <= stamp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a consistent stream of arrivals and checks on a moving clock; the rest
  // is noise with arbitrary or stale timestamps.
  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    now  = now + $urandom_range(0, 12);
    if (pick < 80) begin
      send_item(($urandom_range(0, 9) < 6) ? OP_ENQUEUE : OP_CHECK, HANDLE_W'($urandom), now);
    end else if (pick < 90) begin
      send_item(1'($urandom_range(0, 1)), HANDLE_W'($urandom), $urandom);
    end else begin
      send_item(1'($urandom_range(0, 1)), HANDLE_W'($urandom), now - $urandom_range(1, 50));
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] reg_value;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_DELAY_TIMEOUT;
    cfg_data              <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.operation     <= OP_ENQUEUE;
    item_ch.packet_handle <= '0;
    item_ch.timestamp     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings after reset: every handle is due at once, full burst.
    send_item(OP_CHECK, 16'h0000, 32'h0000_0000);
    send_item(OP_ENQUEUE, 16'h0000, 32'h0000_0000);
    send_item(OP_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_CHECK, 16'hFFFF, 32'h0000_0000);
    wait_idle();

    // Largest timeout, and a burst field of zero which acts as one.
    write_reg(REG_DELAY_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_MAX_RELEASE, 32'hFFFF_FFC0);
    send_item(OP_ENQUEUE, 16'h1234, 32'd5);
    send_item(OP_CHECK, 16'h0000, 32'd3);
    send_item(OP_CHECK, 16'h0000, 32'd4);
    wait_idle();

    // Due entries stay queued once the burst limit is reached.
    write_reg(REG_DELAY_TIMEOUT, 32'd10);
    write_reg(REG_MAX_RELEASE, 32'd1);
    send_item(OP_ENQUEUE, 16'hA5A5, 32'd100);
    send_item(OP_ENQUEUE, 16'h5A5A, 32'd100);
    send_item(OP_ENQUEUE, 16'h8001, 32'd100);
    send_item(OP_CHECK, 16'h0000, 32'd109);
    send_item(OP_CHECK, 16'h0000, 32'd110);
    send_item(OP_CHECK, 16'h0000, 32'd110);
    send_item(OP_CHECK, 16'h0000, 32'd200);
    send_item(OP_CHECK, 16'h0000, 32'd200);
    wait_idle();

    // A run of arrivals while the result side is held off part way, so the input stalls.
    write_reg(REG_DELAY_TIMEOUT, 32'd0);
    write_reg(REG_MAX_RELEASE, 32'd32);
    now = $urandom;
    for (int i = 0; i < 60; i++) begin
      if (i == 20) hold_request = 1'b1;
      now = now + $urandom_range(0, 3);
      send_item(OP_ENQUEUE, HANDLE_W'($urandom), now);
    end
    wait_idle();

    // A burst field above the maximum is clipped, so this drains 32 at a time.
    reg_value = $urandom;
    reg_value[MAX_RELEASE_W-1:0] = '1;
    write_reg(REG_MAX_RELEASE, reg_value);
    repeat (3) send_item(OP_CHECK, HANDLE_W'($urandom), now);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: reg_value = 32'd0;
        1: reg_value = $urandom_range(5, 40);
        2: reg_value = $urandom_range(40, 150);
        default: reg_value = $urandom_range(0, 60);
      endcase
      write_reg(REG_DELAY_TIMEOUT, reg_value);
      reg_value = $urandom;
      case (phase)
        0: reg_value[MAX_RELEASE_W-1:0] = 6'd1;
        1: reg_value[MAX_RELEASE_W-1:0] = MAX_RELEASE_W'($urandom_range(2, 8));
        2: reg_value[MAX_RELEASE_W-1:0] = 6'd0;
        default: reg_value[MAX_RELEASE_W-1:0] = MAX_RELEASE_W'($urandom_range(0, 63));
      endcase
      write_reg(REG_MAX_RELEASE, reg_value);
      for (int i = 0; i < 50; i++) begin
        if (phase == 1 && i == 10) hold_request = 1'b1;
        random_item();
      end
      wait_idle();
    end

    // Final stretch at full rate on both sides.
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    write_reg(REG_DELAY_TIMEOUT, $urandom_range(0, 20));
    write_reg(REG_MAX_RELEASE, 32'd32);
    repeat (40) random_item();
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
